// ----- design/crc16pf_pkg.sv -----
// ----------------------------------------------------------------------------
// crc16pf_pkg
// shared constants, result type and crc-16/ccitt-false byte update
// ----------------------------------------------------------------------------
package crc16pf_pkg;

  localparam int unsigned MaxPayloadDef = 256;
  localparam int unsigned MaxResults    = 7;
  localparam int unsigned CntW          = $clog2(MaxResults + 1);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [7:0]  Sync0   = 8'hAA;
  localparam logic [7:0]  Sync1   = 8'h55;

  localparam logic KindStart   = 1'b0;
  localparam logic KindPayload = 1'b1;

  // result bytes of one item, slot 0 goes out first
  typedef struct packed {
    logic [CntW-1:0]                 cnt;
    logic [MaxResults-1:0]           ends;
    logic [MaxResults-1:0][7:0]      bytes;
  } res_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- design/crc16pf_engine.sv -----
// ----------------------------------------------------------------------------
// crc16pf_engine
// frame state and crc register; turns one item into its result bytes
// ----------------------------------------------------------------------------
module crc16pf_engine #(
  parameter int unsigned MaxPayload = crc16pf_pkg::MaxPayloadDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  logic               kind_i,
  input  logic [7:0]         frame_type_i,
  input  logic [15:0]        frame_length_i,
  input  logic [7:0]         data_byte_i,
  output crc16pf_pkg::res_t  res_o
);

  localparam logic [15:0] MaxLen = 16'(MaxPayload);

  logic [15:0] crc_q, crc_d;
  logic [15:0] keep_q, keep_d;
  logic [15:0] total_q, total_d;
  logic        in_frame_q, in_frame_d;

  logic [15:0] kept;
  logic [15:0] crc_type;
  logic [15:0] crc_lo;
  logic [15:0] crc_hdr;
  logic [15:0] crc_data;
  logic [15:0] total_dec;

  always_comb begin
    kept      = (frame_length_i > MaxLen) ? MaxLen : frame_length_i;
    crc_type  = crc16pf_pkg::crc_fold(crc16pf_pkg::CrcInit, frame_type_i);
    crc_lo    = crc16pf_pkg::crc_fold(crc_type, kept[7:0]);
    crc_hdr   = crc16pf_pkg::crc_fold(crc_lo, kept[15:8]);
    crc_data  = crc16pf_pkg::crc_fold(crc_q, data_byte_i);
    total_dec = (total_q != 16'd0) ? (total_q - 16'd1) : total_q;

    crc_d      = crc_q;
    keep_d     = keep_q;
    total_d    = total_q;
    in_frame_d = in_frame_q;
    res_o      = '0;

    if (item_valid_i) begin
      if (kind_i == crc16pf_pkg::KindStart) begin
        crc_d      = crc_hdr;
        keep_d     = kept;
        total_d    = frame_length_i - kept;
        in_frame_d = 1'b1;
        res_o.bytes[0] = crc16pf_pkg::Sync0;
        res_o.bytes[1] = crc16pf_pkg::Sync1;
        res_o.bytes[2] = frame_type_i;
        res_o.bytes[3] = kept[7:0];
        res_o.bytes[4] = kept[15:8];
        res_o.bytes[5] = crc_hdr[7:0];
        res_o.bytes[6] = crc_hdr[15:8];
        if (kept == 16'd0) begin
          res_o.cnt     = crc16pf_pkg::CntW'(7);
          res_o.ends[6] = 1'b1;
          if (frame_length_i == 16'd0) begin
            in_frame_d = 1'b0;
          end
        end else begin
          res_o.cnt = crc16pf_pkg::CntW'(5);
        end
      end else if (in_frame_q) begin
        if (keep_q != 16'd0) begin
          crc_d          = crc_data;
          keep_d         = keep_q - 16'd1;
          res_o.bytes[0] = data_byte_i;
          res_o.bytes[1] = crc_data[7:0];
          res_o.bytes[2] = crc_data[15:8];
          if (keep_q == 16'd1) begin
            res_o.cnt     = crc16pf_pkg::CntW'(3);
            res_o.ends[2] = 1'b1;
            if (total_q == 16'd0) begin
              in_frame_d = 1'b0;
            end
          end else begin
            res_o.cnt = crc16pf_pkg::CntW'(1);
          end
        end else begin
          // bytes past the clamped length are swallowed
          total_d = total_dec;
          if (total_dec == 16'd0) begin
            in_frame_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= crc16pf_pkg::CrcInit;
      keep_q     <= '0;
      total_q    <= '0;
      in_frame_q <= 1'b0;
    end else begin
      crc_q      <= crc_d;
      keep_q     <= keep_d;
      total_q    <= total_d;
      in_frame_q <= in_frame_d;
    end
  end

endmodule

// ----- design/crc16_packet_framer_top.sv -----
// ----------------------------------------------------------------------------
// crc16_packet_framer_top
// telemetry frame builder with crc-16/ccitt-false trailer
// ----------------------------------------------------------------------------
// input stream: one beat per item; tuser is the kind (0 = start frame,
// 1 = payload byte), tdata carries type, declared length and payload byte.
// a start beat yields sync AA 55, type, clamped length (low byte first) and,
// for an empty frame, the crc right away. payload beats are echoed until the
// clamped count is reached, then the crc follows low byte first with tlast
// on its high byte. excess payload and stray payload produce nothing.
// output stream: one byte per beat, tlast marks the end of a frame.
// an accepted beat waits in the input register, then loads its result bytes
// into the result buffer. throughput: one input beat per cycle while each
// item yields at most one byte and the receiver is ready; a longer item
// holds off the next until the single-byte output port has drained the
// seven-slot result buffer to its last byte. a stalled receiver holds the
// buffer; the input register takes one more beat and then deasserts tready.
// reset empties both and clears the frame state, crc register back to FFFF.
// ----------------------------------------------------------------------------
module crc16_packet_framer_top #(
  parameter int unsigned MaxPayload = crc16pf_pkg::MaxPayloadDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // frame_type[7:0], frame_length[23:8], data_byte[31:24]
  input  logic        s_axis_tuser_i,   // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // out_byte[7:0]
  output logic        m_axis_tlast_o    // frame_end
);

  localparam int unsigned CntW = crc16pf_pkg::CntW;
  localparam int unsigned NRes = crc16pf_pkg::MaxResults;

  logic              in_valid_q;
  logic [31:0]       in_data_q;
  logic              in_user_q;

  logic [NRes-1:0][7:0] buf_bytes_q;
  logic [NRes-1:0]      buf_ends_q;
  logic [CntW-1:0]      cnt_q;

  logic              out_take;
  logic              buf_free;
  logic              proc;
  logic              in_take;
  crc16pf_pkg::res_t res;

  assign out_take        = m_axis_tvalid_o && m_axis_tready_i;
  assign buf_free        = (cnt_q == '0) || ((cnt_q == CntW'(1)) && m_axis_tready_i);
  assign proc            = in_valid_q && buf_free;
  assign s_axis_tready_o = !in_valid_q || proc;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = buf_bytes_q[0];
  assign m_axis_tlast_o  = buf_ends_q[0];

  crc16pf_engine #(
    .MaxPayload(MaxPayload)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (proc),
    .kind_i         (in_user_q),
    .frame_type_i   (in_data_q[7:0]),
    .frame_length_i (in_data_q[23:8]),
    .data_byte_i    (in_data_q[31:24]),
    .res_o          (res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= s_axis_tdata_i;
      in_user_q <= s_axis_tuser_i;
    end
  end

  // result buffer, shifts one byte per output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (proc) begin
      cnt_q <= res.cnt;
    end else if (out_take) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      buf_bytes_q <= res.bytes;
      buf_ends_q  <= res.ends;
    end else if (out_take) begin
      buf_bytes_q <= buf_bytes_q >> 8;
      buf_ends_q  <= buf_ends_q >> 1;
    end
  end

  // frame end only on the last byte an item produced
  a_last_is_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (cnt_q == CntW'(1)))
    else $error("tlast on a byte that is not the last of its item");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(NRes))
    else $error("result buffer count out of range");

  a_load_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |-> (res.cnt == CntW'(0) || res.cnt == CntW'(1) || res.cnt == CntW'(3) ||
              res.cnt == CntW'(5) || res.cnt == CntW'(7)))
    else $error("unexpected number of result bytes");

  a_load_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && (cnt_q == CntW'(1))) |-> out_take)
    else $error("result buffer overwritten before its last byte left");

endmodule
